FILE: design/aabbbp_pkg.sv
// ============================================================================
// aabbbp_pkg
// Shared constants, codes and control types of the 2D box broadphase block.
// ============================================================================
package aabbbp_pkg;

    // table size and coordinate precision
    localparam int MAX_SHAPES = 8;
    localparam int COORD_BITS = 16;

    // fixed field widths
    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 3;
    localparam int IN_COORD_W = 16;
    localparam int TAG_W      = 16;
    localparam int KIND_W     = 2;
    localparam int HANDLE_W   = 3;

    // derived widths
    localparam int IDX_W = $clog2(MAX_SHAPES);
    localparam int CNT_W = $clog2(MAX_SHAPES + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int BOX_W = 4 * COORD_BITS;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_MOVE   = 2'd2,
        FN_FIND   = 2'd3
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KD_ACK  = 2'd0,
        KD_PAIR = 2'd1,
        KD_NONE = 2'd2,
        KD_FULL = 2'd3
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic             op_go;   // run a table op on the accepted item
        logic             adv;     // pair pipeline advances this cycle
        logic             issue;   // a real pair is read this cycle
        logic             finish;  // close the scan, emit the final item
        logic [IDX_W-1:0] rd_a;
        logic [IDX_W-1:0] rd_b;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic             out_free;
        logic             hit;
        logic             pend_valid;
        logic [CNT_W-1:0] used_cnt;
    } t_stat;

endpackage

FILE: design/aabbbp_ram.sv
// ============================================================================
// aabbbp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module aabbbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/aabbbp_ctrl.sv
// ============================================================================
// aabbbp_ctrl
// Sequencer: input handshake, pair counters and scan control.
// ============================================================================
module aabbbp_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic [aabbbp_pkg::FUNC_W-1:0]        i_func,
    output logic                                 o_in_ready,
    input  aabbbp_pkg::t_stat                    i_stat,
    output aabbbp_pkg::t_cmd                     o_cmd
);
    import aabbbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic             r_iss, n_iss;

    logic             stall;
    logic [CNT_W-1:0] j_inc;
    logic [CNT_W-1:0] i_two;

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_iss      = r_iss;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_a = r_i;
        o_cmd.rd_b = r_j;
        j_inc      = CNT_W'(r_j) + CNT_W'(1);
        i_two      = CNT_W'(r_i) + CNT_W'(2);
        // a new hit can only displace the held pair if the output can take it
        stall      = i_stat.hit && i_stat.pend_valid && !i_stat.out_free;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (t_func'(i_func) == FN_FIND) begin
                        n_i = '0;
                        n_j = IDX_W'(1);
                        if (i_stat.used_cnt >= CNT_W'(2)) begin
                            n_iss   = 1'b1;
                            n_state = ST_SCAN;
                        end else begin
                            n_iss   = 1'b0;
                            n_state = ST_DONE;
                        end
                    end else begin
                        o_cmd.op_go = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.adv   = !stall;
                o_cmd.issue = r_iss;
                if (!stall) begin
                    if (r_iss) begin
                        if (j_inc == i_stat.used_cnt) begin
                            n_i   = r_i + IDX_W'(1);
                            n_j   = IDX_W'(i_two);
                            n_iss = (i_two < i_stat.used_cnt);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end else begin
                        // last pair leaves the compare stage this cycle
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_iss   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_iss   <= n_iss;
        end
    end

endmodule

FILE: design/aabbbp_dp.sv
// ============================================================================
// aabbbp_dp
// Datapath: box/tag stores, live marks, free stack, overlap compare,
// held pair and output register.
// ============================================================================
module aabbbp_dp (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  aabbbp_pkg::t_cmd                          i_cmd,
    output aabbbp_pkg::t_stat                         o_stat,
    input  logic [aabbbp_pkg::FUNC_W-1:0]             i_func,
    input  logic [aabbbp_pkg::SLOT_W-1:0]             i_slot,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_min_x,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_min_y,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_max_x,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_max_y,
    input  logic [aabbbp_pkg::TAG_W-1:0]              i_user_tag,
    input  logic                                      i_out_ready,
    output logic                                      o_out_valid,
    output logic [aabbbp_pkg::KIND_W-1:0]             o_kind,
    output logic [aabbbp_pkg::HANDLE_W-1:0]           o_handle,
    output logic [aabbbp_pkg::TAG_W-1:0]              o_tag_a,
    output logic [aabbbp_pkg::TAG_W-1:0]              o_tag_b,
    output logic                                      o_last
);
    import aabbbp_pkg::*;

    // control state
    logic [MAX_SHAPES-1:0] r_live, n_live;
    logic [CNT_W-1:0]      r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]      r_used_cnt, n_used_cnt;
    logic                  r_s1_valid, n_s1_valid;
    logic                  r_pend_valid, n_pend_valid;
    logic                  r_out_valid, n_out_valid;

    // payload
    logic [IDX_W-1:0]      r_stack [MAX_SHAPES];
    logic                  r_s1_live, n_s1_live;
    logic [TAG_W-1:0]      r_pend_a, n_pend_a;
    logic [TAG_W-1:0]      r_pend_b, n_pend_b;
    t_kind                 r_kind;
    logic [HANDLE_W-1:0]   r_handle;
    logic [TAG_W-1:0]      r_tag_a, r_tag_b;
    logic                  r_last;

    // store ports
    logic                  box_we, tag_we;
    logic [IDX_W-1:0]      waddr;
    logic [BOX_W-1:0]      box_wdata;
    logic [BOX_W-1:0]      box_q_a, box_q_b;
    logic [TAG_W-1:0]      tag_q_a, tag_q_b;

    logic                  stack_we;
    logic [IDX_W-1:0]      stack_waddr;

    logic                  slot_used;
    logic [IDX_W-1:0]      slot_idx;
    logic [CNT_W-1:0]      top;
    logic                  hit;
    logic                  out_free;

    logic                  load;
    t_kind                 ld_kind;
    logic [HANDLE_W-1:0]   ld_handle;
    logic [TAG_W-1:0]      ld_a, ld_b;
    logic                  ld_last;

    logic signed [COORD_BITS-1:0] a_min_x, a_min_y, a_max_x, a_max_y;
    logic signed [COORD_BITS-1:0] b_min_x, b_min_y, b_max_x, b_max_y;

    // only the low COORD_BITS of each corner are kept
    assign box_wdata = {i_max_y[COORD_BITS-1:0], i_max_x[COORD_BITS-1:0],
                        i_min_y[COORD_BITS-1:0], i_min_x[COORD_BITS-1:0]};

    // duplicated stores so both slots of a pair read in the same cycle
    aabbbp_ram #(.WIDTH(BOX_W), .DEPTH(MAX_SHAPES)) u_box_a (
        .i_clk(i_clk), .i_we(box_we), .i_waddr(waddr), .i_wdata(box_wdata),
        .i_re(i_cmd.adv), .i_raddr(i_cmd.rd_a), .o_rdata(box_q_a)
    );
    aabbbp_ram #(.WIDTH(BOX_W), .DEPTH(MAX_SHAPES)) u_box_b (
        .i_clk(i_clk), .i_we(box_we), .i_waddr(waddr), .i_wdata(box_wdata),
        .i_re(i_cmd.adv), .i_raddr(i_cmd.rd_b), .o_rdata(box_q_b)
    );
    aabbbp_ram #(.WIDTH(TAG_W), .DEPTH(MAX_SHAPES)) u_tag_a (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(waddr), .i_wdata(i_user_tag),
        .i_re(i_cmd.adv), .i_raddr(i_cmd.rd_a), .o_rdata(tag_q_a)
    );
    aabbbp_ram #(.WIDTH(TAG_W), .DEPTH(MAX_SHAPES)) u_tag_b (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(waddr), .i_wdata(i_user_tag),
        .i_re(i_cmd.adv), .i_raddr(i_cmd.rd_b), .o_rdata(tag_q_b)
    );

    assign a_min_x = box_q_a[0*COORD_BITS +: COORD_BITS];
    assign a_min_y = box_q_a[1*COORD_BITS +: COORD_BITS];
    assign a_max_x = box_q_a[2*COORD_BITS +: COORD_BITS];
    assign a_max_y = box_q_a[3*COORD_BITS +: COORD_BITS];
    assign b_min_x = box_q_b[0*COORD_BITS +: COORD_BITS];
    assign b_min_y = box_q_b[1*COORD_BITS +: COORD_BITS];
    assign b_max_x = box_q_b[2*COORD_BITS +: COORD_BITS];
    assign b_max_y = box_q_b[3*COORD_BITS +: COORD_BITS];

    // closed-interval overlap on both axes
    assign hit = r_s1_valid && r_s1_live &&
                 (a_min_x <= b_max_x) && (b_min_x <= a_max_x) &&
                 (a_min_y <= b_max_y) && (b_min_y <= a_max_y);

    assign out_free  = !r_out_valid || i_out_ready;
    assign slot_used = (CMP_W'(i_slot) < CMP_W'(r_used_cnt));
    assign slot_idx  = IDX_W'(i_slot);
    assign top       = r_free_cnt - CNT_W'(1);

    assign o_stat.out_free   = out_free;
    assign o_stat.hit        = hit;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.used_cnt   = r_used_cnt;

    always_comb begin
        n_live       = r_live;
        n_free_cnt   = r_free_cnt;
        n_used_cnt   = r_used_cnt;
        n_s1_valid   = r_s1_valid;
        n_s1_live    = r_s1_live;
        n_pend_valid = r_pend_valid;
        n_pend_a     = r_pend_a;
        n_pend_b     = r_pend_b;
        box_we       = 1'b0;
        tag_we       = 1'b0;
        waddr        = slot_idx;
        stack_we     = 1'b0;
        stack_waddr  = IDX_W'(r_free_cnt);
        load         = 1'b0;
        ld_kind      = KD_ACK;
        ld_handle    = '0;
        ld_a         = '0;
        ld_b         = '0;
        ld_last      = 1'b1;

        if (i_cmd.op_go) begin
            load = 1'b1;
            case (t_func'(i_func))
                FN_ADD: begin
                    if (r_free_cnt != '0) begin
                        // reuse most recently freed slot
                        waddr        = r_stack[IDX_W'(top)];
                        n_free_cnt   = top;
                        box_we       = 1'b1;
                        tag_we       = 1'b1;
                        n_live[waddr] = 1'b1;
                        ld_handle    = HANDLE_W'(waddr);
                    end else if (r_used_cnt < CNT_W'(MAX_SHAPES)) begin
                        waddr        = IDX_W'(r_used_cnt);
                        n_used_cnt   = r_used_cnt + CNT_W'(1);
                        box_we       = 1'b1;
                        tag_we       = 1'b1;
                        n_live[waddr] = 1'b1;
                        ld_handle    = HANDLE_W'(waddr);
                    end else begin
                        ld_kind = KD_FULL;
                    end
                end
                FN_REMOVE: begin
                    ld_handle = i_slot;
                    if (slot_used && r_live[slot_idx] &&
                        (r_free_cnt < CNT_W'(MAX_SHAPES))) begin
                        n_live[slot_idx] = 1'b0;
                        stack_we         = 1'b1;
                        n_free_cnt       = r_free_cnt + CNT_W'(1);
                    end
                end
                FN_MOVE: begin
                    ld_handle = i_slot;
                    if (slot_used) begin
                        box_we = 1'b1;
                    end
                end
                default: begin
                    load = 1'b0;
                end
            endcase
        end

        if (i_cmd.adv) begin
            n_s1_valid = i_cmd.issue;
            n_s1_live  = r_live[i_cmd.rd_a] && r_live[i_cmd.rd_b];
            if (hit) begin
                // one-deep hold: the held pair is sent only once a later one
                // proves it is not the final item
                if (r_pend_valid) begin
                    load    = 1'b1;
                    ld_kind = KD_PAIR;
                    ld_a    = r_pend_a;
                    ld_b    = r_pend_b;
                    ld_last = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_a     = tag_q_a;
                n_pend_b     = tag_q_b;
            end
        end

        if (i_cmd.finish) begin
            load         = 1'b1;
            n_pend_valid = 1'b0;
            if (r_pend_valid) begin
                ld_kind = KD_PAIR;
                ld_a    = r_pend_a;
                ld_b    = r_pend_b;
            end else begin
                ld_kind = KD_NONE;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live       <= '0;
            r_free_cnt   <= '0;
            r_used_cnt   <= '0;
            r_s1_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_live       <= n_live;
            r_free_cnt   <= n_free_cnt;
            r_used_cnt   <= n_used_cnt;
            r_s1_valid   <= n_s1_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[stack_waddr] <= slot_idx;
        end
        r_s1_live <= n_s1_live;
        r_pend_a  <= n_pend_a;
        r_pend_b  <= n_pend_b;
        if (load) begin
            r_kind   <= ld_kind;
            r_handle <= ld_handle;
            r_tag_a  <= ld_a;
            r_tag_b  <= ld_b;
            r_last   <= ld_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_handle    = r_handle;
    assign o_tag_a     = r_tag_a;
    assign o_tag_b     = r_tag_b;
    assign o_last      = r_last;

endmodule

FILE: design/aabb_pair_broadphase.sv
// ============================================================================
// aabb_pair_broadphase
// Brute-force 2D box broadphase over a small fixed table: add, remove, move,
// and a pair scan that reports every overlapping live pair.
// ============================================================================
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-----------------------------------
//  in       | i_in_valid   | o_in_ready   | func, slot, box corners, user_tag
//  out      | o_out_valid  | i_out_ready  | kind, handle, tag_a, tag_b, last
//
//  Add, remove and move: the item is accepted and its single
//  result is loaded into the output register on the same edge.
//  Find pairs walks pairs i<j of used slots through the duplicated box stores,
//  one pair per cycle except while the scan pauses.
//  Reset clears live marks, free and used counts; box and tag stores are not
//  cleared, since no slot is read before it has been added.
//  The scan pauses only while a new hit meets a held pair and a full output.
// ============================================================================
module aabb_pair_broadphase (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // input channel
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic [aabbbp_pkg::FUNC_W-1:0]             i_func,
    input  logic [aabbbp_pkg::SLOT_W-1:0]             i_slot,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_min_x,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_min_y,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_max_x,
    input  logic signed [aabbbp_pkg::IN_COORD_W-1:0]  i_max_y,
    input  logic [aabbbp_pkg::TAG_W-1:0]              i_user_tag,
    // output channel
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic [aabbbp_pkg::KIND_W-1:0]             o_kind,
    output logic [aabbbp_pkg::HANDLE_W-1:0]           o_handle,
    output logic [aabbbp_pkg::TAG_W-1:0]              o_tag_a,
    output logic [aabbbp_pkg::TAG_W-1:0]              o_tag_b,
    output logic                                      o_last
);
    import aabbbp_pkg::*;

    t_cmd  cmd;   // sequencer commands
    t_stat stat;  // datapath status back to the sequencer

    // Sequencer: owns the handshake on the input side, the pair counters
    // (i, j) and the scan phases.
    aabbbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: stores, free stack, overlap compare, one-deep pair hold (so
    // the final pair can carry last) and the output register.
    aabbbp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_func),
        .i_slot      (i_slot),
        .i_min_x     (i_min_x),
        .i_min_y     (i_min_y),
        .i_max_x     (i_max_x),
        .i_max_y     (i_max_y),
        .i_user_tag  (i_user_tag),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_handle    (o_handle),
        .o_tag_a     (o_tag_a),
        .o_tag_b     (o_tag_b),
        .o_last      (o_last)
    );

endmodule
